// ===== rtl/code_lock_with_display_scan_top_defines.svh =====
// assertion macros for the code lock top level
// no dependencies; included by files that carry concurrent checks
`ifndef CODE_LOCK_WITH_DISPLAY_SCAN_TOP_DEFINES_SVH
`define CODE_LOCK_WITH_DISPLAY_SCAN_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CLDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clds_pkg.sv =====
// shared types, constants and tables for the code lock with display scan
// no dependencies
package clds_pkg;

    localparam int DEFAULT_CODE_DIGITS = 6;
    localparam int DISPLAY_COUNT       = 6;
    localparam int DISP_W              = 3;
    localparam int SEG_W               = 8;
    localparam int KEY_W               = 4;
    localparam int PERIOD_W            = 8;
    localparam int S_TDATA_W           = 8;
    localparam int M_TDATA_W           = 24;

    typedef logic [SEG_W-1:0]  seg_t;
    typedef logic [DISP_W-1:0] disp_t;

    localparam seg_t BLANK_PATTERN = 8'hFF;
    localparam logic [PERIOD_W-1:0] REFRESH_RESET = 8'd10;

    localparam disp_t DISP_FIRST = 3'd0;
    localparam disp_t DISP_BANK_HIGH = 3'd3;
    localparam disp_t DISP_LAST = 3'(DISPLAY_COUNT - 1);

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_STORED,
        EV_OPENED,
        EV_WRONG
    } lock_event_t;

    // active-low patterns for keys 0..F
    localparam seg_t SEG_TABLE [16] = '{
        8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78,
        8'h80, 8'h18, 8'h08, 8'h03, 8'h46, 8'h21, 8'h06, 8'h0E
    };

    localparam logic [2:0] EN_FIRST  = 3'b011;
    localparam logic [2:0] EN_SECOND = 3'b101;
    localparam logic [2:0] EN_THIRD  = 3'b110;

    typedef struct packed {
        disp_t      disp;
        logic [2:0] enables;
        logic       bank;
    } scan_status_t;

    typedef struct packed {
        seg_t        segment;
        logic        lock_open;
        logic [2:0]  digits;
        lock_event_t evt;
    } key_status_t;

    function automatic logic [2:0] enable_pattern(input disp_t disp);
        logic [2:0] pattern;
        unique case (disp)
            3'd0, 3'd3: pattern = EN_FIRST;
            3'd1, 3'd4: pattern = EN_SECOND;
            3'd2, 3'd5: pattern = EN_THIRD;
            default:    pattern = EN_FIRST;
        endcase
        return pattern;
    endfunction

endpackage

// ===== rtl/code_lock_with_display_scan_top.sv =====
// top level of the code lock with six-display seven-segment scan
// depends on clds_pkg, clds_scan, clds_keypath and the assertion macro header
//
// Each request is either a millisecond tick (s_tuser = 0) or a key press
// (s_tuser = 1, key in s_tdata[3:0]) and gives exactly one result. A request
// enters an input register. When the result register is free or being read,
// the lock and scan state is updated and the result is loaded into a result
// register driving m_tvalid. One request is taken every cycle as long as the
// result side keeps up, the input register and result register being the
// only stages. Six key presses enter a code: an open lock stores it and
// closes, a closed lock opens if it matches the stored one. The user must
// write the display period through cfg_wr_en and cfg_wr_data only while no
// request is in flight, unenforced by the block. No clearing pass follows reset.
`include "code_lock_with_display_scan_top_defines.svh"

module code_lock_with_display_scan_top
    import clds_pkg::*;
#(
    parameter int CODE_DIGITS = DEFAULT_CODE_DIGITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [PERIOD_W-1:0]  cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key_value[3:0], zeros
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // segment_byte[7:0], middle_bar[8], digit_enables[11:9], bank_select[12],
    // lock_open[13], digits_entered[16:14], lock_event[18:17], zeros
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic             in_valid_reg;
    logic             in_type_reg;
    logic [KEY_W-1:0] in_key_reg;
    logic             out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic             advance;
    logic             step;
    scan_status_t     scan_status;
    key_status_t      key_status;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= s_tuser;
            in_key_reg  <= s_tdata[KEY_W-1:0];
        end
    end

    clds_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .req_type    (in_type_reg),
        .status      (scan_status)
    );

    clds_keypath #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_keypath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .req_type  (in_type_reg),
        .key_value (in_key_reg),
        .disp      (scan_status.disp),
        .status    (key_status)
    );

    assign out_data_next = {
        5'b00000,
        key_status.evt,
        key_status.digits,
        key_status.lock_open,
        scan_status.bank,
        scan_status.enables,
        key_status.segment[6],
        key_status.segment
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // input side only stalls behind a held result
    `CLDS_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled without a held result")
    // a completed code always leaves the entry buffer empty
    `CLDS_ASSERT_NOW(a_evt_clears, aclk, aresetn, m_tvalid && (m_tdata[18:17] != EV_NONE), m_tdata[16:14] == 3'd0, "entry count not cleared after code")
    // storing a code closes the lock, a match opens it
    `CLDS_ASSERT_NOW(a_evt_lock, aclk, aresetn, m_tvalid && (m_tdata[18:17] == EV_STORED || m_tdata[18:17] == EV_OPENED), m_tdata[13] == (m_tdata[18:17] == EV_OPENED), "lock state disagrees with event")
    // an accepted request always reaches the result register
    `CLDS_ASSERT_NEXT(a_step_result, aclk, aresetn, step, m_tvalid, "accepted request produced no result")

endmodule

// ===== rtl/clds_scan.sv =====
// display scan: refresh tick counter, active display, bank select, period register
// depends on clds_pkg
module clds_scan
    import clds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data,
    input  logic                step,
    input  logic                req_type,
    output scan_status_t        status
);

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] tick_reg, tick_next, tick_inc;
    disp_t               disp_reg, disp_next;
    logic                bank_reg, bank_next;

    always_comb begin
        tick_inc  = tick_reg + 8'd1;
        tick_next = tick_reg;
        disp_next = disp_reg;
        bank_next = bank_reg;
        if (req_type == REQ_TICK) begin
            if (tick_inc >= period_reg) begin
                tick_next = '0;
                disp_next = (disp_reg == DISP_LAST) ? DISP_FIRST : disp_reg + 3'd1;
                if (disp_next == DISP_FIRST) begin
                    bank_next = 1'b0;
                end else if (disp_next == DISP_BANK_HIGH) begin
                    bank_next = 1'b1;
                end
            end else begin
                tick_next = tick_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= REFRESH_RESET;
            tick_reg   <= '0;
            disp_reg   <= DISP_FIRST;
            bank_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (step) begin
                tick_reg <= tick_next;
                disp_reg <= disp_next;
                bank_reg <= bank_next;
            end
        end
    end

    assign status.disp    = disp_next;
    assign status.enables = enable_pattern(disp_next);
    assign status.bank    = bank_next;

endmodule

// ===== rtl/clds_keypath.sv =====
// key path: entry buffer, stored code, lock state and segment select
// depends on clds_pkg
module clds_keypath
    import clds_pkg::*;
#(
    parameter int CODE_DIGITS = DEFAULT_CODE_DIGITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             req_type,
    input  logic [KEY_W-1:0] key_value,
    input  disp_t            disp,
    output key_status_t      status
);

    localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int CNT_W = $clog2(CODE_DIGITS + 1);

    seg_t             entry_reg [CODE_DIGITS];
    seg_t             entry_next[CODE_DIGITS];
    seg_t             entry_wr  [CODE_DIGITS];
    seg_t             code_reg  [CODE_DIGITS];
    seg_t             code_next [CODE_DIGITS];
    logic [CNT_W-1:0] count_reg, count_next, count_inc;
    logic             open_reg, open_next;
    logic             mismatch;
    lock_event_t      evt;
    logic [IDX_W+2:0] disp_wide;
    logic [IDX_W-1:0] disp_idx;
    logic [CNT_W+2:0] count_wide;

    always_comb begin
        entry_wr = entry_reg;
        entry_wr[count_reg[IDX_W-1:0]] = SEG_TABLE[key_value];
        count_inc = count_reg + CNT_W'(1);
        mismatch = 1'b0;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            mismatch = mismatch | (entry_wr[i] != code_reg[i]);
        end

        entry_next = entry_reg;
        code_next  = code_reg;
        count_next = count_reg;
        open_next  = open_reg;
        evt        = EV_NONE;
        if (req_type == REQ_KEY) begin
            if (count_inc == CNT_W'(CODE_DIGITS)) begin
                if (open_reg) begin
                    code_next = entry_wr;
                    open_next = 1'b0;
                    evt       = EV_STORED;
                end else if (!mismatch) begin
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        code_next[i] = BLANK_PATTERN;
                    end
                    open_next = 1'b1;
                    evt       = EV_OPENED;
                end else begin
                    evt = EV_WRONG;
                end
                for (int i = 0; i < CODE_DIGITS; i++) begin
                    entry_next[i] = BLANK_PATTERN;
                end
                count_next = '0;
            end else begin
                entry_next = entry_wr;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
                entry_reg[i] <= BLANK_PATTERN;
                code_reg[i]  <= BLANK_PATTERN;
            end
            count_reg <= '0;
            open_reg  <= 1'b1;
        end else if (step) begin
            entry_reg <= entry_next;
            code_reg  <= code_next;
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

    assign disp_wide  = {{IDX_W{1'b0}}, disp};
    assign disp_idx   = disp_wide[IDX_W-1:0];
    assign count_wide = {3'b000, count_next};

    assign status.segment   = (int'(disp) < CODE_DIGITS) ? entry_next[disp_idx]
                                                         : BLANK_PATTERN;
    assign status.lock_open = open_next;
    assign status.digits    = count_wide[2:0];
    assign status.evt       = evt;

endmodule
